[sv/rcmt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcmt_pkg
// Shared constants and types for the range raise / range minimum block.
// ----------------------------------------------------------------------------
package rcmt_pkg;

    localparam int MAX_LENGTH = 1024;
    localparam int VALUE_BITS = 32;
    localparam int ADDR_W     = $clog2(MAX_LENGTH);
    localparam int POS_W      = 11;

    localparam logic KIND_QUERY = 1'b0;
    localparam logic KIND_RAISE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic clear_wr;
        logic load;
        logic scan_rd;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic load_empty;
        logic scan_last;
        logic kind_raise;
        logic out_free;
    } status_t;

endpackage

[sv/rcmt_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcmt_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rcmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/rcmt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcmt_ctrl
// Sequencer: clear sweep, item intake, element scan and result hand-off.
// ----------------------------------------------------------------------------
module rcmt_ctrl
    import rcmt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    kind,
    input  logic    cfg_we,
    input  status_t status,
    output cmd_t    cmd,
    output logic    in_stall
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = cfg_we;
                if (in_valid && !cfg_we)
                begin
                    cmd.load = 1'b1;
                    if (!status.load_empty)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (kind == KIND_QUERY)
                    begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                state_next = status.kind_raise ? ST_IDLE : ST_RESULT;
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        // a new length restarts the array
        if (cfg_we)
        begin
            state_next = ST_CLEAR;
        end
    end

endmodule

[sv/rcmt_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcmt_dp
// Element store, scan address, raise write-back, running minimum, output reg.
// ----------------------------------------------------------------------------
module rcmt_dp
    import rcmt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic                  cfg_we,
    input  logic [POS_W-1:0]      cfg_data,
    input  logic                  kind,
    input  logic [POS_W-1:0]      left_pos,
    input  logic [POS_W-1:0]      right_pos,
    input  logic [VALUE_BITS-1:0] raise_value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [VALUE_BITS-1:0] min_value,
    output logic [POS_W-1:0]      min_position
);

    localparam logic [POS_W-1:0]  LEN_MAX  = POS_W'(MAX_LENGTH);
    localparam logic [ADDR_W-1:0] ADDR_TOP = ADDR_W'(MAX_LENGTH - 1);

    logic [POS_W-1:0]      len_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [ADDR_W-1:0]     end_reg;
    logic                  kind_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic                  rd_v_reg;
    logic [ADDR_W-1:0]     rd_addr_reg;
    logic [VALUE_BITS-1:0] best_reg;
    logic [POS_W-1:0]      pos_reg;
    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] min_value_reg;
    logic [POS_W-1:0]      min_position_reg;

    logic [POS_W-1:0]      l_clamp;
    logic [POS_W-1:0]      r_clamp;
    logic [POS_W-1:0]      len_next;
    logic [VALUE_BITS-1:0] rd_data;
    logic [VALUE_BITS-1:0] raised;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;

    assign l_clamp = (left_pos == '0) ? POS_W'(1) : left_pos;
    assign r_clamp = (right_pos > len_reg) ? len_reg : right_pos;

    always_comb
    begin
        len_next = cfg_data;
        if (cfg_data == '0)
        begin
            len_next = POS_W'(1);
        end
        else if (cfg_data > LEN_MAX)
        begin
            len_next = LEN_MAX;
        end
    end

    assign raised    = (rd_data > val_reg) ? rd_data : val_reg;
    assign ram_we    = cmd.clear_wr || (rd_v_reg && kind_reg == KIND_RAISE);
    assign ram_waddr = cmd.clear_wr ? addr_reg : rd_addr_reg;
    assign ram_wdata = cmd.clear_wr ? '0 : raised;

    rcmt_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_LENGTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (rd_data)
    );

    always_comb
    begin
        status.clear_last = (addr_reg == ADDR_TOP);
        status.load_empty = (l_clamp > r_clamp);
        status.scan_last  = (addr_reg == end_reg);
        status.kind_raise = (kind_reg == KIND_RAISE);
        status.out_free   = !out_valid_reg || !out_stall;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= LEN_MAX;
            addr_reg      <= '0;
            rd_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                len_reg <= len_next;
            end
            if (cfg_we)
            begin
                addr_reg <= '0;
            end
            else if (cmd.load)
            begin
                addr_reg <= ADDR_W'(l_clamp - POS_W'(1));
            end
            else if (cmd.clear_wr || cmd.scan_rd)
            begin
                addr_reg <= addr_reg + ADDR_W'(1);
            end
            rd_v_reg <= cmd.scan_rd;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        rd_addr_reg <= addr_reg;
        if (cmd.load)
        begin
            end_reg  <= ADDR_W'(r_clamp - POS_W'(1));
            kind_reg <= kind;
            val_reg  <= raise_value;
            best_reg <= '1;
            pos_reg  <= '0;
        end
        else if (rd_v_reg && kind_reg == KIND_QUERY)
        begin
            // strict compare keeps the leftmost position
            if (pos_reg == '0 || rd_data < best_reg)
            begin
                best_reg <= rd_data;
                pos_reg  <= POS_W'(rd_addr_reg) + POS_W'(1);
            end
        end
        if (cmd.emit)
        begin
            min_value_reg    <= best_reg;
            min_position_reg <= pos_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign min_value    = min_value_reg;
    assign min_position = min_position_reg;

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(out_valid_reg && out_stall))
        else $error("result overwritten while held");

    a_no_clear_scan: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.clear_wr && rd_v_reg))
        else $error("clear sweep overlaps scan write-back");

    a_none_is_ones: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && min_position_reg == '0 |-> min_value_reg == '1)
        else $error("empty result without all-ones minimum");

    a_pos_in_len: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> pos_reg <= len_reg)
        else $error("reported position beyond used length");

endmodule

[sv/range_chmax_min_argmin_tree.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_chmax_min_argmin_tree
// Range raise / range minimum with leftmost position of the minimum.
// ----------------------------------------------------------------------------
// The array of MAX_LENGTH values lives in one dual-port RAM and every item
// walks its clamped range one element per cycle, a rate set by the single
// RAM read port. After the scan, a tail state waits out the registered read
// and the write-back of the last element; a query then loads the output
// register, and an empty range skips the scan. After reset and after every
// used_length write the block sweeps the RAM to zero and holds in_stall high
// meanwhile. A finished result sits in the output register, so a new item is
// taken while the old result waits; a query only waits for out_stall at
// hand-off.
// ----------------------------------------------------------------------------
module range_chmax_min_argmin_tree
    import rcmt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [POS_W-1:0]      cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  kind,
    input  logic [POS_W-1:0]      left_pos,
    input  logic [POS_W-1:0]      right_pos,
    input  logic [VALUE_BITS-1:0] raise_value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [VALUE_BITS-1:0] min_value,
    output logic [POS_W-1:0]      min_position
);

    cmd_t    cmd;
    status_t status;

    // sequencer
    rcmt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .cfg_we   (cfg_we),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // storage, scan and result transfer
    rcmt_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .kind         (kind),
        .left_pos     (left_pos),
        .right_pos    (right_pos),
        .raise_value  (raise_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .min_value    (min_value),
        .min_position (min_position)
    );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the range raise / range minimum block.
// A queue of transfers feeds a bursty driver; a monitor with its own stall
// pattern compares each query result against a flat-array model of the
// values, built from scratch at reset and at every length write.
// ----------------------------------------------------------------------------
module tb;
    import rcmt_pkg::*;

    typedef struct {
        logic                  kind;
        logic [POS_W-1:0]      left_pos;
        logic [POS_W-1:0]      right_pos;
        logic [VALUE_BITS-1:0] raise_value;
    } op_t;

    typedef struct {
        logic [VALUE_BITS-1:0] min_value;
        logic [POS_W-1:0]      min_position;
    } ans_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [POS_W-1:0]      cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  kind = KIND_QUERY;
    logic [POS_W-1:0]      left_pos = '0;
    logic [POS_W-1:0]      right_pos = '0;
    logic [VALUE_BITS-1:0] raise_value = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [VALUE_BITS-1:0] min_value;
    logic [POS_W-1:0]      min_position;

    range_chmax_min_argmin_tree dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
        .left_pos(left_pos), .right_pos(right_pos), .raise_value(raise_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .min_value(min_value), .min_position(min_position)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Flat copy of the array; positions past the used length are left out of every range.
    logic [VALUE_BITS-1:0] shadow_vals [1:MAX_LENGTH];
    int unsigned           shadow_len;
    op_t                   pending_ops [$];
    ans_t                  expected_answers [$];
    int unsigned           mismatches = 0;
    bit                    hold_sender = 1'b0;

    function automatic void shadow_clear(input int unsigned len);
        shadow_len = len;
        for (int i = 1; i <= MAX_LENGTH; i++)
            shadow_vals[i] = '0;
    endfunction

    // Apply one accepted transfer; queries push their expected answer.
    function automatic void shadow_apply(input op_t op);
        int unsigned lo;
        int unsigned hi;
        ans_t        a;
        lo = (op.left_pos < 1) ? 1 : op.left_pos;
        hi = (op.right_pos > shadow_len) ? shadow_len : op.right_pos;
        if (op.kind == KIND_RAISE) begin
            for (int i = lo; i <= hi; i++)
                if (shadow_vals[i] < op.raise_value)
                    shadow_vals[i] = op.raise_value;
        end else begin
            a.min_value    = '1;
            a.min_position = '0;
            for (int i = lo; i <= hi; i++)
                if (a.min_position == 0 || shadow_vals[i] < a.min_value) begin
                    a.min_value    = shadow_vals[i];
                    a.min_position = POS_W'(i);
                end
            expected_answers.push_back(a);
        end
    endfunction

    function automatic op_t rand_op(input int unsigned span);
        op_t o;
        int unsigned a;
        o.kind = 1'($urandom_range(0, 1));
        a = $urandom_range(1, span);
        o.left_pos = POS_W'(a);
        o.right_pos = ($urandom_range(0, 9) == 0) ? POS_W'($urandom_range(1, span))
                                                  : POS_W'(a + $urandom_range(0, 40));
        case ($urandom_range(0, 3))
            0: o.raise_value = $urandom_range(0, 20);
            1: o.raise_value = $urandom;
            2: o.raise_value = '1 - $urandom_range(0, 3);
            default: o.raise_value = $urandom_range(0, 1000);
        endcase
        if ($urandom_range(0, 30) == 0) o.left_pos = '0;
        if ($urandom_range(0, 30) == 0) o.right_pos = POS_W'($urandom_range(0, 2047));
        if ($urandom_range(0, 30) == 0) o.left_pos = POS_W'($urandom_range(0, 2047));
        return o;
    endfunction

    // Driver: bursts of transfers separated by random gaps.
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    always @(posedge clk)
    begin
        op_t nxt;
        if (rst_n) begin
            if (!in_valid || !in_stall) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending_ops.size() != 0 && !hold_sender) begin
                    nxt = pending_ops.pop_front();
                    shadow_apply(nxt);
                    in_valid    <= 1'b1;
                    kind        <= nxt.kind;
                    left_pos    <= nxt.left_pos;
                    right_pos   <= nxt.right_pos;
                    raise_value <= nxt.raise_value;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0
                                                                 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall pattern in runs, compare against the oldest answer.
    int unsigned stall_run = 0;
    always @(posedge clk)
    begin
        ans_t e;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_answers.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result %h @%0d", min_value, min_position);
                end else begin
                    e = expected_answers.pop_front();
                    if (e.min_value !== min_value || e.min_position !== min_position) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: exp %h @%0d got %h @%0d", e.min_value,
                                     e.min_position, min_value, min_position);
                    end
                end
            end
            if (stall_run == 0) begin
                stall_run <= $urandom_range(1, 20);
                case ($urandom_range(0, 2))
                    0: out_stall <= 1'b0;
                    1: out_stall <= 1'b1;
                    default: out_stall <= 1'($urandom_range(0, 1));
                endcase
            end else begin
                stall_run <= stall_run - 1;
            end
        end
    end

    task automatic wait_drained();
        while (pending_ops.size() != 0 || in_valid || expected_answers.size() != 0)
            @(posedge clk);
        // a raise yields nothing: give the block time to finish its walk
        repeat (MAX_LENGTH + 20) @(posedge clk);
    endtask

    task automatic write_length(input logic [POS_W-1:0] len);
        int unsigned eff;
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= len;
        eff = (len < 1) ? 1 : ((len > MAX_LENGTH) ? MAX_LENGTH : len);
        shadow_clear(eff);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic add(input logic k, input int unsigned l, input int unsigned r,
                       input logic [VALUE_BITS-1:0] v);
        op_t o;
        o.kind = k;
        o.left_pos = POS_W'(l);
        o.right_pos = POS_W'(r);
        o.raise_value = v;
        pending_ops.push_back(o);
    endtask

    initial
    begin
        int unsigned lens [5];
        shadow_clear(MAX_LENGTH);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, clamps, empty ranges, all-ones values
        add(KIND_QUERY, 1, 1024, 0);
        add(KIND_RAISE, 0, 2047, 32'hFFFF_FFFF);
        add(KIND_QUERY, 1, 1024, 0);
        add(KIND_QUERY, 0, 2047, 0);
        add(KIND_RAISE, 5, 3, 7);
        add(KIND_QUERY, 9, 2, 0);
        add(KIND_QUERY, 1025, 2047, 0);
        add(KIND_QUERY, 1024, 1024, 0);
        add(KIND_QUERY, 0, 0, 0);
        add(KIND_RAISE, 1, 1, 0);
        add(KIND_QUERY, 1, 1, 32'hAAAA_5555);
        add(KIND_RAISE, 1, 1, 32'h5555_AAAA);
        add(KIND_RAISE, 1, 1, 32'hAAAA_5555);
        add(KIND_QUERY, 1, 3, 0);
        wait_drained();

        write_length(POS_W'(3));
        add(KIND_RAISE, 1, 1024, 10);
        add(KIND_RAISE, 2, 2, 5);
        add(KIND_QUERY, 1, 2047, 0);
        add(KIND_QUERY, 4, 1024, 0);
        add(KIND_RAISE, 2, 3, 11);
        add(KIND_QUERY, 0, 3, 0);
        wait_drained();

        lens = '{1, 0, 2047, 64, 1024};
        foreach (lens[p]) begin
            write_length(POS_W'(lens[p]));
            for (int i = 0; i < 250; i++)
                pending_ops.push_back(rand_op((lens[p] == 64) ? 80 : 200));
            // pause the sender mid-phase until the answers are all back
            while (pending_ops.size() > 125) @(posedge clk);
            hold_sender = 1'b1;
            while (in_valid || expected_answers.size() != 0) @(posedge clk);
            hold_sender = 1'b0;
            wait_drained();
        end
        // one full-width raise and query at the largest length
        add(KIND_RAISE, 1, 1024, $urandom);
        add(KIND_QUERY, 0, 2047, 0);
        wait_drained();

        if (mismatches == 0 && expected_answers.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #100ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
sv/rcmt_pkg.sv
sv/rcmt_ram.sv
sv/rcmt_ctrl.sv
sv/rcmt_dp.sv
sv/range_chmax_min_argmin_tree.sv
tb/tb.sv
